>>> sv/dgh_pkg.sv
// ----------------------------------------------------------------------------
// dgh_pkg: shared constants and helpers for the dual GNSS heading core
// Fixed-point formats, pi constants, the CORDIC arctangent table and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package dgh_pkg;

  localparam int ANGLE_FRAC_BITS = 28;
  localparam int ANGLE_W = 32;
  localparam int ROT_W = 33;
  localparam int VEC_W = 63;
  localparam int GAIN_FRAC = 16;
  localparam int MOD_STEPS = 8;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = 8'd1;

  localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;

  function automatic logic signed [63:0] rshr64(input logic signed [63:0] v, input int s);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (s - 1))) >>> s;
    return r;
  endfunction

  localparam logic signed [31:0] PI_F = 32'(rshr64(PI_Q60, 60 - ANGLE_FRAC_BITS));
  localparam logic signed [31:0] HALF_PI_F = 32'(rshr64(PI_Q60, 61 - ANGLE_FRAC_BITS));
  localparam logic signed [31:0] TWO_PI_F = 32'(rshr64(PI_Q60 * 2, 60 - ANGLE_FRAC_BITS));

  localparam logic signed [31:0] CORDIC_KINV = 32'sd652032874;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
  localparam logic signed [31:0] LON_MAX = 32'sd1800000000;
  localparam logic signed [25:0] OFFSET_MAX = 26'sd23592960;
  localparam logic signed [23:0] GAIN_RESET = 24'sd65536;

  localparam logic signed [31:0] DEG7 = 32'(PI_Q60 / 64'sd1800000000);
  localparam logic signed [35:0] DEGQ40 = 36'((PI_Q60 / 180) >>> 20);

  function automatic logic signed [63:0] series_term(input int k, input logic signed [63:0] p);
    logic signed [63:0] t;
    case (k)
      0: t = p;
      1: t = p / 3;
      2: t = p / 5;
      3: t = p / 7;
      4: t = p / 9;
      5: t = p / 11;
      6: t = p / 13;
      7: t = p / 15;
      8: t = p / 17;
      9: t = p / 19;
      10: t = p / 21;
      11: t = p / 23;
      12: t = p / 25;
      13: t = p / 27;
      14: t = p / 29;
      15: t = p / 31;
      16: t = p / 33;
      17: t = p / 35;
      18: t = p / 37;
      19: t = p / 39;
      20: t = p / 41;
      21: t = p / 43;
      22: t = p / 45;
      23: t = p / 47;
      24: t = p / 49;
      25: t = p / 51;
      26: t = p / 53;
      27: t = p / 55;
      28: t = p / 57;
      29: t = p / 59;
      30: t = p / 61;
      default: t = 64'sd0;
    endcase
    return t;
  endfunction

  // Arctangent of 2^-i in the angle format, from the odd power series at 2^62.
  function automatic logic signed [31:0] atan_q(input int i);
    logic signed [63:0] v;
    logic signed [63:0] t;
    int e;
    int k;
    v = 64'sd0;
    if (i == 0) begin
      v = PI_Q60;
    end else begin
      for (k = 0; k < 31; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          t = series_term(k, 64'sd1 <<< (62 - e));
          v = (k % 2 == 1) ? v - t : v + t;
        end
      end
    end
    return 32'(rshr64(v, 62 - ANGLE_FRAC_BITS));
  endfunction

endpackage

>>> sv/dual_gnss_heading_core.sv
// ----------------------------------------------------------------------------
// dual_gnss_heading_core: vehicle heading from a rear and a front antenna
// Great-circle initial bearing by pipelined CORDIC, turned into a heading,
// scaled, offset, wrapped, and given with its yaw quaternion terms.
//
// Usage: each request on the s_ stream carries one pair of antenna fixes
// and yields exactly one result on the m_ stream, in order. The pipeline
// takes one request per cycle while s_tready is high; each request passes
// through the three CORDIC chains in series (sine and cosine of the inputs,
// arctangent, sine and cosine of the half heading) plus the multiply and
// remainder stages. Results leave through a two-entry output buffer, so
// s_tready stays high while one result waits; when the sink stalls and the
// buffer fills, the whole pipeline holds and s_tready falls, with nothing
// lost or repeated. Reset empties the pipeline and the buffer and sets the
// gain to 1.0 and the offset to zero. The user must let the cfg channel
// write a register only while the core is idle; the core does not enforce
// this. The scaled offset is registered. cfg_ready is always high.
// ----------------------------------------------------------------------------
module dual_gnss_heading_core #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // rear_latitude[30:0], rear_longitude[62:31], front_latitude[93:63],
  // front_longitude[125:94], zero fill [127:126]
  input  logic [127:0]                      s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // heading_rad[31:0], quat_z[63:32], quat_w[95:64]
  output logic [95:0]                       m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dgh_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dgh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic signed [23:0] gain;
  logic signed [25:0] offset;
  logic signed [25:0] off_cl;
  logic signed [31:0] off_rad;

  logic en;
  logic [1:0] ocount;
  logic [95:0] obuf0, obuf1;
  logic push, pop;

  logic signed [30:0] in_rlat, in_flat;
  logic signed [31:0] in_rlon, in_flon;
  logic signed [30:0] c_rlat, c_flat;
  logic signed [31:0] c_rlon, c_flon;

  logic a_vld, b_vld, c_vld;
  logic signed [30:0] a_rlat, a_flat;
  logic signed [31:0] a_rlon, a_flon;
  logic signed [63:0] b_plat_r, b_plat_f;
  logic signed [64:0] b_pdl;
  logic signed [31:0] c_tb, c_tf, c_dl;

  logic r_vld;
  logic signed [31:0] sb, cb, sf, cf, sd, cd;

  logic m1_vld, m2_vld, m3_vld, m4_vld;
  logic signed [63:0] m1_py, m1_pa, m1_pb;
  logic signed [31:0] m1_cd, m2_cd, m2_t;
  logic signed [63:0] m2_py, m2_pa, m3_py, m3_pa, m3_pc;
  logic signed [dgh_pkg::VEC_W-1:0] m4_x, m4_y;

  logic v_vld;
  logic signed [31:0] bearing;
  logic h1_vld;
  logic signed [32:0] h1_d;
  logic h_vld;
  logic signed [31:0] h;
  logic g1_vld, g2_vld;
  logic signed [55:0] g1_p;
  logic signed [40:0] g2_s;
  logic t_vld;
  logic signed [31:0] tot;
  logic q_vld;
  logic signed [31:0] qz, qw, heading;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= dgh_pkg::GAIN_RESET;
      offset <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dgh_pkg::REG_GAIN: gain <= cfg_data[23:0];
        dgh_pkg::REG_OFFSET: offset <= cfg_data[25:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (offset > dgh_pkg::OFFSET_MAX) begin
      off_cl = dgh_pkg::OFFSET_MAX;
    end else if (offset < -dgh_pkg::OFFSET_MAX) begin
      off_cl = -dgh_pkg::OFFSET_MAX;
    end else begin
      off_cl = offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off_rad <= '0;
    end else begin
      off_rad <= 32'(dgh_pkg::rshr64(64'(off_cl) * 64'(dgh_pkg::DEGQ40),
                                     56 - dgh_pkg::ANGLE_FRAC_BITS));
    end
  end

  assign en = (ocount != 2'd2);
  assign s_tready = en;

  always_comb begin
    in_rlat = s_tdata[30:0];
    in_rlon = s_tdata[62:31];
    in_flat = s_tdata[93:63];
    in_flon = s_tdata[125:94];
    c_rlat = (in_rlat > dgh_pkg::LAT_MAX) ? dgh_pkg::LAT_MAX :
             (in_rlat < -dgh_pkg::LAT_MAX) ? -dgh_pkg::LAT_MAX : in_rlat;
    c_flat = (in_flat > dgh_pkg::LAT_MAX) ? dgh_pkg::LAT_MAX :
             (in_flat < -dgh_pkg::LAT_MAX) ? -dgh_pkg::LAT_MAX : in_flat;
    c_rlon = (in_rlon > dgh_pkg::LON_MAX) ? dgh_pkg::LON_MAX :
             (in_rlon < -dgh_pkg::LON_MAX) ? -dgh_pkg::LON_MAX : in_rlon;
    c_flon = (in_flon > dgh_pkg::LON_MAX) ? dgh_pkg::LON_MAX :
             (in_flon < -dgh_pkg::LON_MAX) ? -dgh_pkg::LON_MAX : in_flon;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
      m4_vld <= 1'b0;
      h1_vld <= 1'b0;
      g1_vld <= 1'b0;
      g2_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_tvalid;
      b_vld <= a_vld;
      c_vld <= b_vld;
      m1_vld <= r_vld;
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
      m4_vld <= m3_vld;
      h1_vld <= v_vld;
      g1_vld <= h_vld;
      g2_vld <= g1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_rlat <= c_rlat;
      a_rlon <= c_rlon;
      a_flat <= c_flat;
      a_flon <= c_flon;

      b_plat_r <= 64'(a_rlat) * 64'(dgh_pkg::DEG7);
      b_plat_f <= 64'(a_flat) * 64'(dgh_pkg::DEG7);
      b_pdl <= (65'(a_flon) - 65'(a_rlon)) * 65'(dgh_pkg::DEG7);

      c_tb <= 32'(dgh_pkg::rshr64(b_plat_r, 60 - dgh_pkg::ANGLE_FRAC_BITS));
      c_tf <= 32'(dgh_pkg::rshr64(b_plat_f, 60 - dgh_pkg::ANGLE_FRAC_BITS));
      c_dl <= 32'((b_pdl + (65'sd1 <<< 31)) >>> 32);

      m1_py <= 64'(sd) * 64'(cf);
      m1_pa <= 64'(cb) * 64'(sf);
      m1_pb <= 64'(sb) * 64'(cf);
      m1_cd <= cd;

      m2_t <= 32'(dgh_pkg::rshr64(m1_pb, 30));
      m2_py <= m1_py;
      m2_pa <= m1_pa;
      m2_cd <= m1_cd;

      m3_pc <= 64'(m2_t) * 64'(m2_cd);
      m3_py <= m2_py;
      m3_pa <= m2_pa;

      m4_x <= dgh_pkg::VEC_W'((m3_pa - m3_pc) >>> 2);
      m4_y <= dgh_pkg::VEC_W'(m3_py >>> 2);

      h1_d <= 33'(dgh_pkg::HALF_PI_F) - 33'(bearing);

      g1_p <= 56'(h) * 56'(gain);
      g2_s <= 41'((g1_p + (56'sd1 <<< (dgh_pkg::GAIN_FRAC - 1))) >>> dgh_pkg::GAIN_FRAC)
              + 41'(off_rad);
    end
  end

  dgh_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_rot_rear (
    .clk(clk), .rst(rst), .en(en), .in_valid(c_vld), .angle(c_tb), .side_in(1'b0),
    .out_valid(r_vld), .sin_q(sb), .cos_q(cb), .side_out()
  );

  dgh_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_rot_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(c_vld), .angle(c_tf), .side_in(1'b0),
    .out_valid(), .sin_q(sf), .cos_q(cf), .side_out()
  );

  dgh_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_rot_dlon (
    .clk(clk), .rst(rst), .en(en), .in_valid(c_vld), .angle(c_dl), .side_in(1'b0),
    .out_valid(), .sin_q(sd), .cos_q(cd), .side_out()
  );

  dgh_vec #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk(clk), .rst(rst), .en(en), .in_valid(m4_vld), .x_in(m4_x), .y_in(m4_y),
    .out_valid(v_vld), .angle(bearing)
  );

  dgh_mod #(.IN_W(33), .STEPS(1)) u_mod_h (
    .clk(clk), .rst(rst), .en(en), .in_valid(h1_vld), .value(h1_d),
    .out_valid(h_vld), .rem(h)
  );

  dgh_mod #(.IN_W(41), .STEPS(dgh_pkg::MOD_STEPS)) u_mod_tot (
    .clk(clk), .rst(rst), .en(en), .in_valid(g2_vld), .value(g2_s),
    .out_valid(t_vld), .rem(tot)
  );

  dgh_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(32)) u_rot_quat (
    .clk(clk), .rst(rst), .en(en), .in_valid(t_vld), .angle(tot >>> 1), .side_in(tot),
    .out_valid(q_vld), .sin_q(qz), .cos_q(qw), .side_out(heading)
  );

  assign push = en && q_vld;
  assign pop = m_tvalid && m_tready;
  assign m_tvalid = (ocount != 2'd0);
  assign m_tdata = obuf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ocount <= 2'd0;
    end else begin
      ocount <= ocount + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (ocount == 2'd2) begin
        obuf0 <= obuf1;
      end else if (push) begin
        obuf0 <= {qw, qz, heading};
      end
    end else if (push) begin
      if (ocount == 2'd0) begin
        obuf0 <= {qw, qz, heading};
      end else begin
        obuf1 <= {qw, qz, heading};
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) ocount != 2'd3)
    else $error("output buffer count out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({a_vld, c_vld, m4_vld, g2_vld}))
    else $error("pipeline moved while stalled");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) < dgh_pkg::TWO_PI_F) &&
                 ($signed(m_tdata[31:0]) > -dgh_pkg::TWO_PI_F))
    else $error("heading outside the open 2*pi interval");

  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[63:32]) <= dgh_pkg::ONE_Q30) &&
                 ($signed(m_tdata[63:32]) >= -dgh_pkg::ONE_Q30) &&
                 ($signed(m_tdata[95:64]) <= dgh_pkg::ONE_Q30) &&
                 ($signed(m_tdata[95:64]) >= -dgh_pkg::ONE_Q30))
    else $error("quaternion term beyond unit range");

endmodule

>>> sv/dgh_mod.sv
// ----------------------------------------------------------------------------
// dgh_mod: pipelined truncating remainder by 2*pi
// One conditional subtract of a shifted 2*pi per stage on the magnitude; the
// sign of the argument is restored at the end.
// ----------------------------------------------------------------------------
module dgh_mod #(
  parameter int IN_W = 33,
  parameter int STEPS = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [IN_W-1:0] value,
  output logic                   out_valid,
  output logic signed [31:0]     rem
);

  localparam int CW = IN_W + STEPS;

  logic            vld [0:STEPS];
  logic            neg [0:STEPS];
  logic [IN_W-1:0] mag [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= value[IN_W-1];
      mag[0] <= value[IN_W-1] ? IN_W'(-value) : IN_W'(value);
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [CW-1:0] SUB = CW'(unsigned'(dgh_pkg::TWO_PI_F)) << (STEPS - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg[j+1] <= neg[j];
        if (CW'(mag[j]) >= SUB) begin
          mag[j+1] <= mag[j] - SUB[IN_W-1:0];
        end else begin
          mag[j+1] <= mag[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= neg[STEPS] ? -signed'(mag[STEPS][31:0]) : signed'(mag[STEPS][31:0]);
    end
  end

endmodule

>>> sv/dgh_rot.sv
// ----------------------------------------------------------------------------
// dgh_rot: pipelined CORDIC sine and cosine
// Three range-reduction stages fold the angle into +-pi/2, one stage per
// CORDIC iteration follows, and a last stage restores the sign and clamps.
// ----------------------------------------------------------------------------
module dgh_rot #(
  parameter int STAGES = 32,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] angle,
  input  logic [SIDE_W-1:0]  side_in,
  output logic               out_valid,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q,
  output logic [SIDE_W-1:0]  side_out
);

  localparam logic signed [dgh_pkg::ROT_W-1:0] ONE_R = dgh_pkg::ROT_W'(dgh_pkg::ONE_Q30);

  logic               p1_vld, p2_vld;
  logic signed [31:0] p1_a, p2_a;
  logic [SIDE_W-1:0]  p1_side, p2_side;

  logic                              cvld  [0:STAGES];
  logic                              cneg  [0:STAGES];
  logic [SIDE_W-1:0]                 cside [0:STAGES];
  logic signed [dgh_pkg::ROT_W-1:0]  cx    [0:STAGES];
  logic signed [dgh_pkg::ROT_W-1:0]  cy    [0:STAGES];
  logic signed [31:0]                cz    [0:STAGES];

  logic signed [dgh_pkg::ROT_W-1:0]  fx, fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      cvld[0] <= 1'b0;
    end else if (en) begin
      p1_vld <= in_valid;
      p2_vld <= p1_vld;
      cvld[0] <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side <= side_in;
      if (angle >= dgh_pkg::TWO_PI_F) begin
        p1_a <= angle - dgh_pkg::TWO_PI_F;
      end else if (angle <= -dgh_pkg::TWO_PI_F) begin
        p1_a <= angle + dgh_pkg::TWO_PI_F;
      end else begin
        p1_a <= angle;
      end

      p2_side <= p1_side;
      if (p1_a > dgh_pkg::PI_F) begin
        p2_a <= p1_a - dgh_pkg::TWO_PI_F;
      end else if (p1_a < -dgh_pkg::PI_F) begin
        p2_a <= p1_a + dgh_pkg::TWO_PI_F;
      end else begin
        p2_a <= p1_a;
      end

      cside[0] <= p2_side;
      cx[0] <= dgh_pkg::ROT_W'(dgh_pkg::CORDIC_KINV);
      cy[0] <= '0;
      if (p2_a > dgh_pkg::HALF_PI_F) begin
        cz[0] <= p2_a - dgh_pkg::PI_F;
        cneg[0] <= 1'b1;
      end else if (p2_a < -dgh_pkg::HALF_PI_F) begin
        cz[0] <= p2_a + dgh_pkg::PI_F;
        cneg[0] <= 1'b1;
      end else begin
        cz[0] <= p2_a;
        cneg[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [31:0] ATAN = dgh_pkg::atan_q(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        cvld[i+1] <= 1'b0;
      end else if (en) begin
        cvld[i+1] <= cvld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cneg[i+1] <= cneg[i];
        cside[i+1] <= cside[i];
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN;
        end
      end
    end
  end

  always_comb begin
    fx = cneg[STAGES] ? -cx[STAGES] : cx[STAGES];
    fy = cneg[STAGES] ? -cy[STAGES] : cy[STAGES];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cvld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= cside[STAGES];
      if (fy > ONE_R) begin
        sin_q <= dgh_pkg::ONE_Q30;
      end else if (fy < -ONE_R) begin
        sin_q <= -dgh_pkg::ONE_Q30;
      end else begin
        sin_q <= 32'(fy);
      end
      if (fx > ONE_R) begin
        cos_q <= dgh_pkg::ONE_Q30;
      end else if (fx < -ONE_R) begin
        cos_q <= -dgh_pkg::ONE_Q30;
      end else begin
        cos_q <= 32'(fx);
      end
    end
  end

endmodule

>>> sv/dgh_vec.sv
// ----------------------------------------------------------------------------
// dgh_vec: pipelined CORDIC arctangent of y over x
// A first stage folds the left half plane onto the right one and flags the
// origin, then one stage per CORDIC iteration drives y toward zero.
// ----------------------------------------------------------------------------
module dgh_vec #(
  parameter int STAGES = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [dgh_pkg::VEC_W-1:0] x_in,
  input  logic signed [dgh_pkg::VEC_W-1:0] y_in,
  output logic                             out_valid,
  output logic signed [31:0]               angle
);

  logic                             cvld  [0:STAGES];
  logic                             czero [0:STAGES];
  logic signed [dgh_pkg::VEC_W-1:0] cx    [0:STAGES];
  logic signed [dgh_pkg::VEC_W-1:0] cy    [0:STAGES];
  logic signed [31:0]               cz    [0:STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld[0] <= 1'b0;
    end else if (en) begin
      cvld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      czero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        cz[0] <= (y_in >= 0) ? dgh_pkg::PI_F : -dgh_pkg::PI_F;
        cx[0] <= -x_in;
        cy[0] <= -y_in;
      end else begin
        cz[0] <= '0;
        cx[0] <= x_in;
        cy[0] <= y_in;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [31:0] ATAN = dgh_pkg::atan_q(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        cvld[i+1] <= 1'b0;
      end else if (en) begin
        cvld[i+1] <= cvld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        czero[i+1] <= czero[i];
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN;
        end
      end
    end
  end

  assign out_valid = cvld[STAGES];
  assign angle = czero[STAGES] ? '0 : cz[STAGES];

endmodule

>>> tb/tb_dual_gnss_heading_core.sv
// ----------------------------------------------------------------------------
// tb_dual_gnss_heading_core: self-checking bench for the dual GNSS heading core
// Drives antenna fix pairs on the input stream under random and forced
// backpressure, predicts heading and yaw quaternion terms with a bit-exact
// fixed-point CORDIC model, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_dual_gnss_heading_core;

  localparam logic [dgh_pkg::CFG_INDEX_W-1:0] REG_SPARE = 8'd5;
  localparam int NSTAGE = 32;
  localparam int LATENCY = 3 * NSTAGE + 32;

  typedef struct packed {
    logic [31:0] quat_w;
    logic [31:0] quat_z;
    logic [31:0] heading_rad;
  } heading_t;

  class heading_board;
    heading_t pending_headings[$];
    longint atan_tab[NSTAGE];
    logic [23:0] gain_reg;
    logic [25:0] offset_reg;
    int errors;

    function new();
      longint v;
      longint term;
      int e;
      for (int i = 0; i < NSTAGE; i++) begin
        v = 0;
        if (i == 0) begin
          v = dgh_pkg::PI_Q60;
        end else begin
          for (int k = 0; k < 40; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
              term = (64'sd1 <<< (62 - e)) / longint'(2 * k + 1);
              v = (k % 2 == 1) ? v - term : v + term;
            end
          end
        end
        atan_tab[i] = round_shift(v, 62 - dgh_pkg::ANGLE_FRAC_BITS);
      end
      gain_reg = 24'd65536;
      offset_reg = '0;
      errors = 0;
    endfunction

    function longint round_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint limit(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint pi_a();
      return round_shift(dgh_pkg::PI_Q60, 60 - dgh_pkg::ANGLE_FRAC_BITS);
    endfunction

    function longint half_pi_a();
      return round_shift(dgh_pkg::PI_Q60, 61 - dgh_pkg::ANGLE_FRAC_BITS);
    endfunction

    function longint two_pi_a();
      return round_shift(dgh_pkg::PI_Q60 * 2, 60 - dgh_pkg::ANGLE_FRAC_BITS);
    endfunction

    function void sin_cos(longint a, output longint s, output longint c);
      longint x, y, z, dx, dy, pi, hp, tp;
      bit neg;
      x = 652032874;
      y = 0;
      pi = pi_a();
      hp = half_pi_a();
      tp = two_pi_a();
      neg = 0;
      a = a % tp;
      if (a > pi) a -= tp;
      if (a < -pi) a += tp;
      if (a > hp) begin
        a -= pi;
        neg = 1;
      end else if (a < -hp) begin
        a += pi;
        neg = 1;
      end
      z = a;
      for (int i = 0; i < NSTAGE; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (z >= 0) begin
          x -= dy; y += dx; z -= atan_tab[i];
        end else begin
          x += dy; y -= dx; z += atan_tab[i];
        end
      end
      if (neg) begin
        x = -x;
        y = -y;
      end
      s = limit(y, 64'sd1 <<< 30);
      c = limit(x, 64'sd1 <<< 30);
    endfunction

    function longint bearing_of(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? pi_a() : -pi_a();
        x = -x;
        y = -y;
      end
      for (int i = 0; i < NSTAGE; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (y > 0) begin
          x += dy; y -= dx; z += atan_tab[i];
        end else begin
          x -= dy; y += dx; z -= atan_tab[i];
        end
      end
      return z;
    endfunction

    function void write_reg(logic [dgh_pkg::CFG_INDEX_W-1:0] idx,
                            logic [dgh_pkg::CFG_DATA_W-1:0] data);
      if (idx == dgh_pkg::REG_GAIN) gain_reg = data[23:0];
      else if (idx == dgh_pkg::REG_OFFSET) offset_reg = data[25:0];
    endfunction

    function void note_fix(logic [127:0] d);
      longint deg7, degq40, tp, rlat, rlon, flat, flon, tb, tf, dl;
      longint sb, cb, sf, cf, sd, cd, yv, xv, brg, h, gain, off, offr, tot, qz, qw;
      heading_t r;
      deg7 = dgh_pkg::PI_Q60 / 64'sd1800000000;
      degq40 = (dgh_pkg::PI_Q60 / 180) >>> 20;
      tp = two_pi_a();
      rlat = limit(longint'($signed(d[30:0])), 900000000);
      rlon = limit(longint'($signed(d[62:31])), 1800000000);
      flat = limit(longint'($signed(d[93:63])), 900000000);
      flon = limit(longint'($signed(d[125:94])), 1800000000);
      tb = round_shift(rlat * deg7, 60 - dgh_pkg::ANGLE_FRAC_BITS);
      tf = round_shift(flat * deg7, 60 - dgh_pkg::ANGLE_FRAC_BITS);
      dl = round_shift((flon - rlon) * deg7, 60 - dgh_pkg::ANGLE_FRAC_BITS);
      sin_cos(tb, sb, cb);
      sin_cos(tf, sf, cf);
      sin_cos(dl, sd, cd);
      yv = sd * cf;
      xv = cb * sf - round_shift(sb * cf, 30) * cd;
      brg = bearing_of(yv >>> 2, xv >>> 2);
      h = (half_pi_a() - brg) % tp;
      gain = longint'($signed(gain_reg));
      off = limit(longint'($signed(offset_reg)), 23592960);
      offr = round_shift(off * degq40, 56 - dgh_pkg::ANGLE_FRAC_BITS);
      tot = (round_shift(h * gain, 16) + offr) % tp;
      sin_cos(tot >>> 1, qz, qw);
      r.heading_rad = tot[31:0];
      r.quat_z = qz[31:0];
      r.quat_w = qw[31:0];
      pending_headings.push_back(r);
    endfunction

    function void check_heading(logic [95:0] d);
      heading_t got, want;
      got = d;
      if (pending_headings.size() == 0) begin
        $error("result with no request outstanding: %h", d);
        errors++;
        return;
      end
      want = pending_headings.pop_front();
      if (got.heading_rad !== want.heading_rad) begin
        $error("heading_rad expected %h actual %h", want.heading_rad, got.heading_rad);
        errors++;
      end
      if (got.quat_z !== want.quat_z) begin
        $error("quat_z expected %h actual %h", want.quat_z, got.quat_z);
        errors++;
      end
      if (got.quat_w !== want.quat_w) begin
        $error("quat_w expected %h actual %h", want.quat_w, got.quat_w);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [127:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [95:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [dgh_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dgh_pkg::CFG_DATA_W-1:0] cfg_data;

  heading_board board;
  bit quiet;
  int results_seen;

  dual_gnss_heading_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 2000000);
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) board.note_fix(s_tdata);
      if (m_tvalid && m_tready) begin
        board.check_heading(m_tdata);
        results_seen++;
      end
    end
  end

  // The sink stalls at random and once holds off long enough to back up the core.
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 20) begin
        held = 1;
        hold = 500;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 0;
      end else begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
      end
    end
  end

  function automatic logic [127:0] pack_fix(longint rlat, longint rlon, longint flat,
                                            longint flon);
    logic [127:0] d;
    d = '0;
    d[30:0] = rlat[30:0];
    d[62:31] = rlon[31:0];
    d[93:63] = flat[30:0];
    d[125:94] = flon[31:0];
    return d;
  endfunction

  task automatic send_fix(logic [127:0] d);
    while (!quiet && $urandom_range(99) < 23) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_cfg(logic [dgh_pkg::CFG_INDEX_W-1:0] idx,
                           logic [dgh_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (board.pending_headings.size() != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
  endtask

  task automatic random_fixes(int n);
    longint rlat, rlon, flat, flon;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70) begin
        rlat = longint'($urandom_range(32'd1800000000)) - 900000000;
        rlon = longint'($urandom_range(32'd3600000000)) - 1800000000;
        flat = rlat + longint'($urandom_range(40000)) - 20000;
        flon = rlon + longint'($urandom_range(40000)) - 20000;
      end else begin
        rlat = longint'($urandom);
        rlon = longint'($urandom);
        flat = longint'($urandom);
        flon = longint'($urandom);
      end
      send_fix(pack_fix(rlat, rlon, flat, flon));
    end
  endtask

  initial begin
    board = new();
    quiet = 0;
    results_seen = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, clamping, coincident antennas, due south, poles.
    send_fix(pack_fix(0, 0, 0, 0));
    send_fix(pack_fix(0, 0, 100, 0));
    send_fix(pack_fix(100, 0, 0, 0));
    send_fix(pack_fix(0, 0, 0, 100));
    send_fix(pack_fix(0, 100, 0, 0));
    send_fix(pack_fix(900000000, 0, -900000000, 0));
    send_fix(pack_fix(-900000000, 1800000000, 900000000, -1800000000));
    send_fix(pack_fix(900000000, -1800000000, 900000000, 1800000000));
    send_fix(pack_fix(-900000000, -1800000000, -900000000, -1800000000));
    send_fix(pack_fix(longint'(31'h3FFFFFFF), longint'(32'h7FFFFFFF),
                      longint'(31'h40000000), longint'(32'h80000000)));
    send_fix(pack_fix(longint'(31'h40000000), longint'(32'h80000000),
                      longint'(31'h3FFFFFFF), longint'(32'h7FFFFFFF)));
    send_fix(pack_fix(longint'(31'h7FFFFFFF), longint'(32'hFFFFFFFF),
                      longint'(31'h7FFFFFFF), longint'(32'hFFFFFFFF)));
    send_fix(pack_fix(450000000, 1200000000, 449999000, 1200000000));
    send_fix(pack_fix(-300000000, -50000000, -300000500, -50000000));
    send_fix(pack_fix(100000000, 1799999000, 100000000, -1799999000));
    send_fix(pack_fix(100000000, -1799999000, 100000000, 1799999000));
    send_fix(pack_fix(899999999, 0, 899999999, 1));
    drain();

    write_cfg(REG_SPARE, 32'hFFFFFFFF);
    write_cfg(dgh_pkg::REG_GAIN, 32'h00800000);
    write_cfg(dgh_pkg::REG_OFFSET, 32'd23592960);
    random_fixes(120);
    drain();

    quiet = 1;
    write_cfg(dgh_pkg::REG_GAIN, 32'h007FFFFF);
    write_cfg(dgh_pkg::REG_OFFSET, 32'h03FFFFFF & (-32'sd23592960));
    random_fixes(120);
    drain();
    quiet = 0;

    write_cfg(dgh_pkg::REG_GAIN, 32'hFF000000);
    write_cfg(dgh_pkg::REG_OFFSET, 32'h01FFFFFF);
    random_fixes(120);
    drain();

    write_cfg(dgh_pkg::REG_GAIN, 32'h00FF0000);
    write_cfg(dgh_pkg::REG_OFFSET, 32'h02000000);
    random_fixes(120);
    drain();

    write_cfg(dgh_pkg::REG_GAIN, $urandom);
    write_cfg(dgh_pkg::REG_OFFSET, $urandom);
    random_fixes(100);
    drain();

    write_cfg(dgh_pkg::REG_GAIN, 32'd65536);
    write_cfg(dgh_pkg::REG_OFFSET, 32'd0);
    random_fixes(120);
    drain();

    if (board.errors == 0 && board.pending_headings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
